// ----- sv/dsa_pkg.sv -----
// Shared types, codes and the power-of-ten table of the decimal scientific ALU.
package dsa_pkg;

    localparam int DIGITS_DEF = 9;
    localparam int MANT_W     = 31;
    localparam int EXPO_W     = 16;
    localparam int MAG_W      = 64;
    localparam int E_W        = 20;
    localparam int PW_IDX_W   = 5;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NHI,
        S_NLO,
        S_OP,
        S_MUL,
        S_DIV,
        S_ADD,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } t_phase;

    // 10^k; indexes past 10^19 read as all ones so a compare against them never passes
    function automatic logic [MAG_W-1:0] pw10(input logic [PW_IDX_W-1:0] k);
        logic [MAG_W-1:0] v;
        case (k)
            5'd0:    v = 64'd1;
            5'd1:    v = 64'd10;
            5'd2:    v = 64'd100;
            5'd3:    v = 64'd1000;
            5'd4:    v = 64'd10000;
            5'd5:    v = 64'd100000;
            5'd6:    v = 64'd1000000;
            5'd7:    v = 64'd10000000;
            5'd8:    v = 64'd100000000;
            5'd9:    v = 64'd1000000000;
            5'd10:   v = 64'd10000000000;
            5'd11:   v = 64'd100000000000;
            5'd12:   v = 64'd1000000000000;
            5'd13:   v = 64'd10000000000000;
            5'd14:   v = 64'd100000000000000;
            5'd15:   v = 64'd1000000000000000;
            5'd16:   v = 64'd10000000000000000;
            5'd17:   v = 64'd100000000000000000;
            5'd18:   v = 64'd1000000000000000000;
            5'd19:   v = 64'd10000000000000000000;
            default: v = '1;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/dsa_if.sv -----
// Request and result channels of the decimal scientific ALU.
interface dsa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic signed [dsa_pkg::MANT_W-1:0] a_mant;
    logic signed [dsa_pkg::EXPO_W-1:0] a_exp;
    logic signed [dsa_pkg::MANT_W-1:0] b_mant;
    logic signed [dsa_pkg::EXPO_W-1:0] b_exp;

    modport source (output valid, req_type, a_mant, a_exp, b_mant, b_exp, input ready);
    modport sink   (input valid, req_type, a_mant, a_exp, b_mant, b_exp, output ready);
endinterface

interface dsa_res_if;
    logic        valid;
    logic        ready;
    logic signed [dsa_pkg::MANT_W-1:0] res_mant;
    logic signed [dsa_pkg::EXPO_W-1:0] res_exp;
    logic [1:0]  status;

    modport source (output valid, res_mant, res_exp, status, input ready);
    modport sink   (input valid, res_mant, res_exp, status, output ready);
endinterface

// ----- sv/decimal_scientific_alu.sv -----
// Decimal scientific ALU: add, subtract, multiply, divide on sequenced shared adder.
//
//  channel  | dir | handshake      | payload
//  i_req    | in  | valid / ready  | req_type, a_mant, a_exp, b_mant, b_exp
//  o_res    | out | valid / ready  | res_mant, res_exp, status
//
// One request at a time; i_req.ready is high only while the sequencer is idle.
// Each scale-down, alignment, multiply or divide pass runs 64 one-bit steps through
// the single 65-bit adder, and each scale-up by ten is one step on the same adder.
// Reset is synchronous; it empties the sequencer and the result register.
// A result waiting on o_res.ready holds in its register; a new request is taken
// once the sequencer returns to idle.
module decimal_scientific_alu #(
    parameter int DIGITS = dsa_pkg::DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dsa_req_if.sink      i_req,
    dsa_res_if.source    o_res
);

    localparam int MW    = dsa_pkg::MAG_W;
    localparam int EW    = dsa_pkg::E_W;
    localparam int IW    = dsa_pkg::PW_IDX_W;
    localparam int CNT_W = $clog2(MW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MW - 1);
    localparam logic [IW-1:0]    D_IDX    = IW'(DIGITS);
    localparam logic [IW-1:0]    D_M1     = IW'(DIGITS - 1);

    dsa_pkg::t_state r_state, n_state, r_ret, n_ret;
    dsa_pkg::t_phase r_phase, n_phase;

    logic [1:0]          r_op, n_op;
    logic [MW-1:0]       r_am, n_am, r_bm, n_bm, r_mag, n_mag;
    logic                r_an, n_an, r_bn, n_bn, r_neg, n_neg, r_swap, n_swap;
    logic signed [EW-1:0] r_ae, n_ae, r_be, n_be, r_e, n_e;
    logic [MW-1:0]       r_hi, n_hi, r_lo, n_lo, r_x, n_x;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [IW-1:0]       r_k, n_k;
    logic [1:0]          r_status, n_status;
    logic                r_ovalid, n_ovalid;
    logic [dsa_pkg::MANT_W-1:0] r_res_mant, n_res_mant;
    logic [dsa_pkg::EXPO_W-1:0] r_res_exp, n_res_exp;
    logic [1:0]          r_res_status, n_res_status;

    // shared adder
    logic [MW:0]   w_opa, w_opb;
    logic          w_sub;
    logic [MW+1:0] w_sum;

    logic [dsa_pkg::MANT_W-1:0] w_a_abs, w_b_abs;
    logic          w_hi_more, w_lo_need, w_last, w_out_free;
    logic          w_a_zero, w_b_zero, w_a_ge_b, w_a_gt, w_sh_big;
    logic signed [EW-1:0] w_ediff, w_sh;
    logic [MW-1:0] w_xm, w_ym, w_src;
    logic          w_ys, w_x_lt_y, w_dsign, w_ge;
    logic [MW:0]   w_mstep;

    assign w_a_abs = i_req.a_mant[dsa_pkg::MANT_W-1] ? -i_req.a_mant : i_req.a_mant;
    assign w_b_abs = i_req.b_mant[dsa_pkg::MANT_W-1] ? -i_req.b_mant : i_req.b_mant;

    assign w_hi_more  = r_mag >= dsa_pkg::pw10(D_IDX + r_k);
    assign w_lo_need  = (r_mag != '0) && (r_mag < dsa_pkg::pw10(D_M1));
    assign w_last     = r_cnt == CNT_LAST;
    assign w_out_free = !r_ovalid || o_res.ready;

    assign w_a_zero = r_am == '0;
    assign w_b_zero = r_bm == '0;
    assign w_a_ge_b = r_am >= r_bm;
    assign w_ediff  = r_ae - r_be;
    assign w_a_gt   = w_ediff > 0;
    assign w_sh     = w_a_gt ? w_ediff : -w_ediff;
    assign w_sh_big = w_sh >= EW'(DIGITS);
    assign w_src    = w_a_gt ? r_bm : r_am;

    assign w_xm     = r_swap ? r_mag : r_am;
    assign w_ym     = r_swap ? r_bm : r_mag;
    assign w_ys     = r_bn ^ (r_op == dsa_pkg::OP_SUB);
    assign w_x_lt_y = w_xm < w_ym;
    assign w_dsign  = r_an ^ w_ys;

    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sub = 1'b0;
        case (r_state)
            dsa_pkg::S_MUL: begin
                w_opa = {1'b0, r_hi};
                w_opb = {1'b0, r_x};
            end
            dsa_pkg::S_DIV: begin
                w_opa = {r_hi, r_lo[MW-1]};
                w_opb = {1'b0, r_x};
                w_sub = 1'b1;
            end
            dsa_pkg::S_NLO: begin
                w_opa = (MW+1)'({r_mag, 3'b000});
                w_opb = (MW+1)'({r_mag, 1'b0});
            end
            dsa_pkg::S_ADD: begin
                w_opa = {1'b0, (w_x_lt_y && w_dsign) ? w_ym : w_xm};
                w_opb = {1'b0, (w_x_lt_y && w_dsign) ? w_xm : w_ym};
                w_sub = w_dsign;
            end
            default: begin
                w_opa = '0;
            end
        endcase
        w_sum = {1'b0, w_opa} + {1'b0, w_opb ^ {(MW+1){w_sub}}} + (MW+2)'(w_sub);
    end

    assign w_ge    = w_sum[MW+1];
    assign w_mstep = r_lo[0] ? w_sum[MW:0] : {1'b0, r_hi};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsa_pkg::S_IDLE: if (i_req.valid) n_state = dsa_pkg::S_NHI;
            dsa_pkg::S_NHI: begin
                if (w_hi_more) n_state = dsa_pkg::S_NHI;
                else if (r_k != '0) n_state = dsa_pkg::S_DIV;
                else n_state = dsa_pkg::S_NLO;
            end
            dsa_pkg::S_NLO: begin
                if (!w_lo_need) begin
                    case (r_phase)
                        dsa_pkg::PH_A: n_state = dsa_pkg::S_NHI;
                        dsa_pkg::PH_B: n_state = dsa_pkg::S_OP;
                        default:       n_state = dsa_pkg::S_FIN;
                    endcase
                end
            end
            dsa_pkg::S_OP: begin
                case (r_op)
                    dsa_pkg::OP_MUL: n_state = (w_a_zero || w_b_zero) ? dsa_pkg::S_FIN
                                                                     : dsa_pkg::S_MUL;
                    dsa_pkg::OP_DIV: n_state = (w_a_zero || w_b_zero) ? dsa_pkg::S_FIN
                                                                     : dsa_pkg::S_MUL;
                    default: begin
                        if (w_a_zero || w_b_zero || w_sh_big || w_sh == '0)
                            n_state = dsa_pkg::S_ADD;
                        else
                            n_state = dsa_pkg::S_DIV;
                    end
                endcase
            end
            dsa_pkg::S_MUL: if (w_last) n_state = dsa_pkg::S_DIV;
            dsa_pkg::S_DIV: if (w_last) n_state = r_ret;
            dsa_pkg::S_ADD: n_state = dsa_pkg::S_NHI;
            dsa_pkg::S_FIN: if (w_out_free) n_state = dsa_pkg::S_IDLE;
            default: n_state = dsa_pkg::S_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_ret = r_ret;   n_phase = r_phase; n_op = r_op;
        n_am = r_am;     n_bm = r_bm;       n_mag = r_mag;
        n_an = r_an;     n_bn = r_bn;       n_neg = r_neg;  n_swap = r_swap;
        n_ae = r_ae;     n_be = r_be;       n_e = r_e;
        n_hi = r_hi;     n_lo = r_lo;       n_x = r_x;
        n_cnt = r_cnt;   n_k = r_k;         n_status = r_status;
        n_res_mant = r_res_mant; n_res_exp = r_res_exp; n_res_status = r_res_status;
        n_ovalid = r_ovalid && !o_res.ready;
        case (r_state)
            dsa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.req_type;
                    n_an     = i_req.a_mant[dsa_pkg::MANT_W-1];
                    n_mag    = MW'(w_a_abs);
                    n_e      = EW'(i_req.a_exp);
                    n_bn     = i_req.b_mant[dsa_pkg::MANT_W-1];
                    n_bm     = MW'(w_b_abs);
                    n_be     = EW'(i_req.b_exp);
                    n_phase  = dsa_pkg::PH_A;
                    n_k      = '0;
                    n_neg    = 1'b0;
                    n_status = dsa_pkg::ST_OK;
                end
            end
            dsa_pkg::S_NHI: begin
                if (w_hi_more) begin
                    n_k = r_k + IW'(1);
                end else if (r_k != '0) begin
                    // drop the excess digits in one pass
                    n_hi  = '0;
                    n_lo  = r_mag;
                    n_x   = dsa_pkg::pw10(r_k);
                    n_e   = r_e + EW'(r_k);
                    n_cnt = '0;
                    n_ret = dsa_pkg::S_NHI;
                end
            end
            dsa_pkg::S_NLO: begin
                if (w_lo_need) begin
                    n_mag = w_sum[MW-1:0];
                    n_e   = r_e - EW'(1);
                end else begin
                    case (r_phase)
                        dsa_pkg::PH_A: begin
                            n_am    = r_mag;
                            n_ae    = r_e;
                            n_mag   = r_bm;
                            n_e     = r_be;
                            n_phase = dsa_pkg::PH_B;
                            n_k     = '0;
                        end
                        dsa_pkg::PH_B: begin
                            n_bm = r_mag;
                            n_be = r_e;
                        end
                        default: begin
                            n_k = '0;
                        end
                    endcase
                end
            end
            dsa_pkg::S_OP: begin
                n_hi  = '0;
                n_cnt = '0;
                case (r_op)
                    dsa_pkg::OP_MUL: begin
                        n_neg = r_an ^ r_bn;
                        n_mag = '0;
                        n_lo  = r_bm;
                        n_x   = r_am;
                        n_e   = r_ae + r_be - EW'(1);
                    end
                    dsa_pkg::OP_DIV: begin
                        n_neg = r_an ^ r_bn;
                        n_mag = '0;
                        if (w_b_zero) n_status = dsa_pkg::ST_DIV0;
                        n_lo  = w_a_ge_b ? dsa_pkg::pw10(D_M1) : dsa_pkg::pw10(D_IDX);
                        n_x   = r_am;
                        n_e   = r_ae - r_be + (w_a_ge_b ? EW'(1) : EW'(0));
                    end
                    default: begin
                        if (w_a_zero) begin
                            n_swap = 1'b1;
                            n_mag  = '0;
                            n_e    = r_be;
                        end else if (w_b_zero) begin
                            n_swap = 1'b0;
                            n_mag  = '0;
                            n_e    = r_ae;
                        end else begin
                            // align the operand with the smaller exponent
                            n_swap = !w_a_gt;
                            n_e    = w_a_gt ? r_ae : r_be;
                            n_mag  = w_sh_big ? '0 : w_src;
                            n_lo   = w_src;
                            n_x    = dsa_pkg::pw10(w_sh[IW-1:0]);
                            n_ret  = dsa_pkg::S_ADD;
                        end
                    end
                endcase
            end
            dsa_pkg::S_MUL: begin
                n_hi  = w_mstep[MW:1];
                n_lo  = {w_mstep[0], r_lo[MW-1:1]};
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last) begin
                    n_x     = (r_op == dsa_pkg::OP_DIV) ? r_bm : dsa_pkg::pw10(D_M1);
                    n_ret   = dsa_pkg::S_NHI;
                    n_phase = dsa_pkg::PH_R;
                end
            end
            dsa_pkg::S_DIV: begin
                n_hi  = w_ge ? w_sum[MW-1:0] : w_opa[MW-1:0];
                n_lo  = {r_lo[MW-2:0], w_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (w_last) begin
                    n_mag = {r_lo[MW-2:0], w_ge};
                    n_k   = '0;
                end
            end
            dsa_pkg::S_ADD: begin
                n_mag   = w_sum[MW-1:0];
                n_neg   = (w_dsign && w_x_lt_y) ? w_ys : r_an;
                n_phase = dsa_pkg::PH_R;
                n_k     = '0;
            end
            dsa_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_ovalid     = 1'b1;
                    n_res_mant   = r_neg ? (dsa_pkg::MANT_W'(0) - r_mag[dsa_pkg::MANT_W-1:0])
                                         : r_mag[dsa_pkg::MANT_W-1:0];
                    n_res_status = r_status;
                    n_res_exp    = r_e[dsa_pkg::EXPO_W-1:0];
                    if (r_mag == '0) begin
                        n_res_exp = '0;
                    end else if (r_e > EW'(32767)) begin
                        n_res_exp    = 16'h7fff;
                        n_res_status = dsa_pkg::ST_SAT;
                    end else if (r_e < -EW'(32768)) begin
                        n_res_exp    = 16'h8000;
                        n_res_status = dsa_pkg::ST_SAT;
                    end
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dsa_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;   r_phase <= n_phase; r_op <= n_op;
        r_am <= n_am;     r_bm <= n_bm;       r_mag <= n_mag;
        r_an <= n_an;     r_bn <= n_bn;       r_neg <= n_neg;  r_swap <= n_swap;
        r_ae <= n_ae;     r_be <= n_be;       r_e <= n_e;
        r_hi <= n_hi;     r_lo <= n_lo;       r_x <= n_x;
        r_cnt <= n_cnt;   r_k <= n_k;         r_status <= n_status;
        r_res_mant <= n_res_mant;
        r_res_exp <= n_res_exp;
        r_res_status <= n_res_status;
    end

    assign i_req.ready    = r_state == dsa_pkg::S_IDLE;
    assign o_res.valid    = r_ovalid;
    assign o_res.res_mant = r_res_mant;
    assign o_res.res_exp  = r_res_exp;
    assign o_res.status   = r_res_status;

endmodule

// ----- sv/dsa_checker.sv -----
// Port-level checks of the decimal scientific ALU, bound to the top level.
module dsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [30:0] i_res_mant,
    input logic [15:0] i_res_exp,
    input logic [1:0]  i_res_status
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_mant)
            && $stable(i_res_exp) && $stable(i_res_status))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_status == dsa_pkg::ST_OK || i_res_status == dsa_pkg::ST_DIV0
            || i_res_status == dsa_pkg::ST_SAT)
        else $error("bad status code");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_status == dsa_pkg::ST_DIV0 |-> i_res_mant == '0
            && i_res_exp == '0)
        else $error("divide by zero result not cleared");

endmodule

bind decimal_scientific_alu dsa_checker u_dsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_mant   (o_res.res_mant),
    .i_res_exp    (o_res.res_exp),
    .i_res_status (o_res.status)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench of the decimal scientific ALU: directed and random requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IDLE_LIMIT = 4000;
    localparam int  DRAIN      = 300;
    localparam longint TEN8    = 64'd100000000;
    localparam longint TEN9    = 64'd1000000000;

    typedef struct packed {
        logic signed [dsa_pkg::MANT_W-1:0] mant;
        logic signed [dsa_pkg::EXPO_W-1:0] expo;
        logic [1:0]                        status;
    } t_dec_result;

    logic i_clk;
    logic i_rst_n;
    dsa_req_if req_ch ();
    dsa_res_if res_ch ();

    decimal_scientific_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    t_dec_result pending_results[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          res_stall = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Bring a nonzero magnitude into [10^8, 10^9).
    function automatic void normalize(inout logic [63:0] mag, inout longint e);
        if (mag == 0) return;
        while (mag >= TEN9) begin mag = mag / 10; e++; end
        while (mag < TEN8) begin mag = mag * 10; e--; end
    endfunction

    function automatic longint drop_digits(longint v, longint n);
        logic [63:0] m;
        bit          neg;
        neg = v < 0;
        m = neg ? -v : v;
        while (n > 0 && m != 0) begin m = m / 10; n--; end
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_dec_result compute_result(logic [1:0] op,
            logic signed [dsa_pkg::MANT_W-1:0] am, logic signed [dsa_pkg::EXPO_W-1:0] ae_in,
            logic signed [dsa_pkg::MANT_W-1:0] bm, logic signed [dsa_pkg::EXPO_W-1:0] be_in);
        t_dec_result  r;
        logic [63:0]  amag, bmag, mag;
        logic [127:0] w;
        longint       ae, be, e, x, y, s;
        bit           an, bn, neg;
        logic [1:0]   st;
        ae = ae_in; be = be_in;
        an = am < 0; bn = bm < 0;
        x = am; y = bm;
        amag = an ? -x : x;
        bmag = bn ? -y : y;
        mag = 0; e = 0; neg = 0; st = dsa_pkg::ST_OK;
        normalize(amag, ae);
        normalize(bmag, be);
        if (op == dsa_pkg::OP_ADD || op == dsa_pkg::OP_SUB) begin
            x = an ? -longint'(amag) : longint'(amag);
            y = bn ? -longint'(bmag) : longint'(bmag);
            if (op == dsa_pkg::OP_SUB) y = -y;
            if (amag == 0) begin s = y; e = be; end
            else if (bmag == 0) begin s = x; e = ae; end
            else if (ae > be) begin s = x + drop_digits(y, ae - be); e = ae; end
            else begin s = drop_digits(x, be - ae) + y; e = be; end
            neg = s < 0;
            mag = neg ? -s : s;
            normalize(mag, e);
        end else if (op == dsa_pkg::OP_MUL) begin
            neg = an != bn;
            if (amag != 0 && bmag != 0) begin
                w = 128'(amag) * 128'(bmag);
                mag = 64'(w / 128'(TEN8));
                if (mag >= TEN9) begin mag = mag / 10; e = ae + be; end
                else e = ae + be - 1;
            end
        end else begin
            neg = an != bn;
            if (bmag == 0) st = dsa_pkg::ST_DIV0;
            else if (amag != 0) begin
                if (amag >= bmag) begin
                    w = 128'(amag) * 128'(TEN8);
                    e = ae - be + 1;
                end else begin
                    w = 128'(amag) * 128'(TEN9);
                    e = ae - be;
                end
                mag = 64'(w / 128'(bmag));
            end
        end
        if (mag == 0) e = 0;
        else if (e > 32767) begin e = 32767; st = dsa_pkg::ST_SAT; end
        else if (e < -32768) begin e = -32768; st = dsa_pkg::ST_SAT; end
        r.mant   = dsa_pkg::MANT_W'(neg ? -mag : mag);
        r.expo   = dsa_pkg::EXPO_W'(e);
        r.status = st;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    task automatic send_request(logic [1:0] op, logic signed [dsa_pkg::MANT_W-1:0] am,
            logic signed [dsa_pkg::EXPO_W-1:0] ae, logic signed [dsa_pkg::MANT_W-1:0] bm,
            logic signed [dsa_pkg::EXPO_W-1:0] be);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.a_mant   <= am;
        req_ch.a_exp    <= ae;
        req_ch.b_mant   <= bm;
        req_ch.b_exp    <= be;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_results.push_back(compute_result(op, am, ae, bm, be));
    endtask

    // Check each result and pace the ready side; the watchdog shares this block.
    always @(posedge i_clk) begin
        t_dec_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            idle_cycles  <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (res_ch.res_mant !== want.mant)
                        report_mismatch("res_mant", res_ch.res_mant, want.mant);
                    if (res_ch.res_exp !== want.expo)
                        report_mismatch("res_exp", res_ch.res_exp, want.expo);
                    if (res_ch.status !== want.status)
                        report_mismatch("status", res_ch.status, want.status);
                end
                res_stall = $urandom_range(0, 3);
            end
            if (res_stall > 0) begin
                res_ch.ready <= 1'b0;
                res_stall--;
            end else begin
                res_ch.ready <= 1'b1;
            end
            if ((res_ch.valid && res_ch.ready) || (req_ch.valid && req_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [dsa_pkg::MANT_W-1:0] rand_mant();
        logic signed [dsa_pkg::MANT_W-1:0] m;
        case ($urandom_range(0, 9))
            0:       m = dsa_pkg::MANT_W'($urandom);
            1:       m = dsa_pkg::MANT_W'($urandom_range(0, 999));
            2:       m = 0;
            default: m = dsa_pkg::MANT_W'($urandom_range(100000000, 999999999));
        endcase
        if ($urandom_range(0, 1)) m = -m;
        return m;
    endfunction

    function automatic logic signed [dsa_pkg::EXPO_W-1:0] rand_exp();
        case ($urandom_range(0, 5))
            0:       return dsa_pkg::EXPO_W'($urandom);
            1:       return $urandom_range(0, 1)
                            ? dsa_pkg::EXPO_W'(16'sd32767 - $urandom_range(0, 5))
                            : dsa_pkg::EXPO_W'(-16'sd32768 + $urandom_range(0, 5));
            default: return dsa_pkg::EXPO_W'($urandom_range(0, 40) - 20);
        endcase
    endfunction

    task automatic test_extremes();
        send_request(dsa_pkg::OP_ADD, 31'sd999999999, 16'sd32767,
                     31'sd999999999, 16'sd32767);
        send_request(dsa_pkg::OP_SUB, -31'sd999999999, -16'sd32768,
                     31'sd999999999, -16'sd32768);
        send_request(dsa_pkg::OP_MUL, 31'sd999999999, 16'sd32767,
                     -31'sd999999999, 16'sd32767);
        send_request(dsa_pkg::OP_MUL, 31'sd100000000, -16'sd32768,
                     31'sd100000000, -16'sd32768);
        send_request(dsa_pkg::OP_DIV, 31'sd999999999, 16'sd32767, 31'sd1, -16'sd32768);
        send_request(dsa_pkg::OP_DIV, 31'sd1, -16'sd32768, 31'sd999999999, 16'sd32767);
        // out-of-range mantissas scale down before the operation
        send_request(dsa_pkg::OP_ADD, 31'h3FFF_FFFF, 16'sd0, -31'sh4000_0000, 16'sd0);
        send_request(dsa_pkg::OP_MUL, -31'sh4000_0000, 16'sd5, 31'h3FFF_FFFF, -16'sd5);
    endtask

    task automatic test_operations();
        send_request(dsa_pkg::OP_ADD, 31'sd123456789, 16'sd3, 31'sd987654321, 16'sd1);
        send_request(dsa_pkg::OP_SUB, 31'sd123456789, 16'sd1, 31'sd987654321, 16'sd3);
        send_request(dsa_pkg::OP_MUL, -31'sd250000000, 16'sd2, 31'sd400000000, 16'sd1);
        send_request(dsa_pkg::OP_DIV, 31'sd1, 16'sd0, 31'sd3, 16'sd0);
        send_request(dsa_pkg::OP_DIV, 31'sd900000000, 16'sd0, -31'sd300000000, 16'sd0);
    endtask

    task automatic test_special_cases();
        // zero operands: exponent of the zero side is ignored
        send_request(dsa_pkg::OP_ADD, 31'sd0, 16'sd500, 31'sd42, 16'sd7);
        send_request(dsa_pkg::OP_SUB, 31'sd0, -16'sd9, 31'sd42, 16'sd7);
        send_request(dsa_pkg::OP_SUB, 31'sd77, 16'sd2, 31'sd0, 16'sd300);
        // exact cancellation gives zero
        send_request(dsa_pkg::OP_SUB, 31'sd555555555, 16'sd4, 31'sd555555555, 16'sd4);
        send_request(dsa_pkg::OP_MUL, 31'sd0, 16'sd12, 31'sd5, 16'sd1);
        send_request(dsa_pkg::OP_DIV, 31'sd5, 16'sd1, 31'sd0, 16'sd9);
        send_request(dsa_pkg::OP_DIV, 31'sd0, 16'sd1, 31'sd0, 16'sd9);
        // alignment drops the whole smaller operand
        send_request(dsa_pkg::OP_ADD, 31'sd1, 16'sd100, 31'sd999999999, -16'sd100);
    endtask

    task automatic test_random();
        logic [1:0] op;
        repeat (1900) begin
            op = 2'($urandom_range(0, 3));
            send_request(op, rand_mant(), rand_exp(), rand_mant(), rand_exp());
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= dsa_pkg::OP_ADD;
        req_ch.a_mant   <= '0;
        req_ch.a_exp    <= '0;
        req_ch.b_mant   <= '0;
        req_ch.b_exp    <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_operations();
        test_special_cases();
        test_random();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
sv/dsa_pkg.sv
sv/dsa_if.sv
sv/decimal_scientific_alu.sv
sv/dsa_checker.sv
bench/tb_top.sv
